// File: hdl/message_queue_dispatcher_top_defines.svh
// assertion macros shared by the message queue dispatcher checkers
// the checker that uses these must have i_clk and i_rst_n in scope
`ifndef MESSAGE_QUEUE_DISPATCHER_TOP_DEFINES_SVH
`define MESSAGE_QUEUE_DISPATCHER_TOP_DEFINES_SVH

// cond in one cycle requires nxt in the following cycle
`define MQD_ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error(msg);

// cond requires cons in the same cycle
`define MQD_ASSERT_IMPLY(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);

`endif

// File: hdl/mqd_pkg.sv
// package for the message queue dispatcher: sizes, codes, state and link types
// no dependencies; imported by every module of the block
package mqd_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int SLOT_COUNT    = 8;
    localparam int PAYLOAD_BYTES = 8;

    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int SLOT_CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int SLOT_IDX_W  = 3;
    localparam int ID_W        = 8;
    localparam int TYPE_W      = 8;
    localparam int PAYLOAD_W   = 64;
    localparam int LEN_W       = 4;
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 4;

    localparam int IN_FIELDS_W  = 3 * ID_W + PAYLOAD_W + LEN_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = SLOT_IDX_W + ID_W + TYPE_W + PAYLOAD_W + LEN_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [ID_W-1:0] ID_NONE      = 8'd0;
    localparam logic [ID_W-1:0] BROADCAST_ID = 8'd255;

    typedef enum logic [ACTION_W-1:0] {
        ACT_REGISTER = 2'd0,
        ACT_PUSH     = 2'd1,
        ACT_DISPATCH = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED       = 4'd0,
        ST_QUEUE_FULL   = 4'd1,
        ST_TOO_LONG     = 4'd2,
        ST_REGISTERED   = 4'd3,
        ST_INVALID_ID   = 4'd4,
        ST_TABLE_FULL   = 4'd5,
        ST_DELIVERY     = 4'd6,
        ST_QUEUE_EMPTY  = 4'd7,
        ST_NO_RECEIVER  = 4'd8
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SINGLE,
        S_READ,
        S_MATCH,
        S_WALK
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]      rcp;
        logic [TYPE_W-1:0]    msg_type;
        logic [PAYLOAD_W-1:0] payload;
        logic [LEN_W-1:0]     len;
    } t_qentry;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic emit_single;
        logic build_mask;
        logic emit_walk;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic q_empty;
        logic out_free;
        logic walk_last;
    } t_dp_sts;

endpackage

// File: hdl/message_queue_dispatcher_top.sv
// message queue dispatcher: service slot table plus message ring with fan-out delivery
// depends on mqd_pkg, mqd_ctrl and mqd_dp
//
// usage:
//   s_axis carries one command beat; tuser selects register (0), push (1) or
//   dispatch (2); a beat with tuser 3 is taken and dropped with no result
//   m_axis returns result beats; tuser is the status code, tlast marks the
//   final beat caused by one command
//   register and push give one beat, sent from S_SINGLE once the output
//   register is free; the block stays busy until that beat is issued
//   dispatch reads the head message (S_READ), builds a match mask over the
//   used slots (S_MATCH), then sends one delivery per cycle from the output
//   register while m_axis is not stalled (S_WALK); a no-receiver or
//   queue-empty status is sent as a single beat; at most eight deliveries,
//   one per slot
//   s_axis_tready is high only between commands; one command is worked at a
//   time, while the last result may still sit in the output register
//   a stalled m_axis holds the output beat and pauses the delivery walk
//   reset (synchronous, active low) empties the slot table and the ring;
//   ring contents are not cleared, the pointers make them unreadable
module message_queue_dispatcher_top
    import mqd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // service_id, recipient, msg_type, payload, payload_length, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action
    input  logic [ACTION_W-1:0]   s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // slot_index, target_service, out_type, out_payload, out_length, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [STATUS_W-1:0]   m_axis_tuser,
    output logic                  m_axis_tlast
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    mqd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_action (s_axis_tuser),
        .i_sts       (sts),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (cmd)
    );

    mqd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_in_data    (s_axis_tdata),
        .i_in_action  (s_axis_tuser),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata),
        .o_out_status (m_axis_tuser),
        .o_out_last   (m_axis_tlast)
    );

endmodule

// File: hdl/mqd_ctrl.sv
// controller state machine of the message queue dispatcher
// depends on mqd_pkg; drives the datapath through t_dp_cmd
module mqd_ctrl
    import mqd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [ACTION_W-1:0] i_in_action,
    input  t_dp_sts             i_sts,
    output logic                o_in_ready,
    output t_dp_cmd             o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_action == ACT_REGISTER || i_in_action == ACT_PUSH) begin
                        n_state = S_SINGLE;
                    end else if (i_in_action == ACT_DISPATCH) begin
                        n_state = S_READ;
                    end
                end
            end
            S_SINGLE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                n_state = i_sts.q_empty ? S_SINGLE : S_MATCH;
            end
            S_MATCH: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (i_sts.out_free && i_sts.walk_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_SINGLE: begin
                o_cmd.emit_single = i_sts.out_free;
            end
            S_READ: begin
            end
            S_MATCH: begin
                o_cmd.build_mask = 1'b1;
            end
            S_WALK: begin
                o_cmd.emit_walk = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: hdl/mqd_dp.sv
// datapath of the message queue dispatcher: slot table, message ring, output register
// depends on mqd_pkg; steered by mqd_ctrl through t_dp_cmd
module mqd_dp
    import mqd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic [ACTION_W-1:0]   i_in_action,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output logic [STATUS_W-1:0]   o_out_status,
    output logic                  o_out_last
);

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // latched input beat
    logic [ACTION_W-1:0]  r_act;
    logic [ID_W-1:0]      r_sid;
    logic [ID_W-1:0]      r_rcp;
    logic [TYPE_W-1:0]    r_type;
    logic [PAYLOAD_W-1:0] r_payload;
    logic [LEN_W-1:0]     r_len;

    // slot table, filled in order and never freed, so a fill count says which are used
    logic [ID_W-1:0]       r_slot [SLOT_COUNT];
    logic [SLOT_CNT_W-1:0] r_slot_cnt;

    // message ring
    t_qentry           r_mem [QUEUE_DEPTH];
    t_qentry           r_rd;
    logic [QPTR_W-1:0] r_head;
    logic [QPTR_W-1:0] r_tail;
    logic [QPTR_W-1:0] tail_next;

    logic [SLOT_COUNT-1:0] r_mask;
    logic [SLOT_COUNT-1:0] mask_n;
    logic [SLOT_COUNT-1:0] mask_clr;
    logic [SLOT_IDX_W-1:0] walk_idx;
    logic                  walk_last;

    t_status               single_status;
    logic [SLOT_IDX_W-1:0] single_slot;
    logic                  slot_ok;
    logic                  push_ok;
    logic                  slot_wr;
    logic                  push_wr;
    logic [PAYLOAD_W-1:0]  payload_masked;

    logic                  r_ovalid;
    logic [STATUS_W-1:0]   r_ostatus;
    logic [SLOT_IDX_W-1:0] r_oslot;
    logic [ID_W-1:0]       r_otarget;
    logic [TYPE_W-1:0]     r_otype;
    logic [PAYLOAD_W-1:0]  r_opayload;
    logic [LEN_W-1:0]      r_olen;
    logic                  r_olast;
    logic                  out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_act     <= i_in_action;
            r_sid     <= i_in_data[ID_W-1:0];
            r_rcp     <= i_in_data[2*ID_W-1:ID_W];
            r_type    <= i_in_data[3*ID_W-1:2*ID_W];
            r_payload <= i_in_data[3*ID_W+PAYLOAD_W-1:3*ID_W];
            r_len     <= i_in_data[IN_FIELDS_W-1:3*ID_W+PAYLOAD_W];
        end
    end

    assign tail_next = ptr_next(r_tail);

    // bytes at or beyond the length are stored as zero
    always_comb begin
        payload_masked = '0;
        for (int b = 0; b < PAYLOAD_W / 8; b++) begin
            if (LEN_W'(b) < r_len) begin
                payload_masked[b*8 +: 8] = r_payload[b*8 +: 8];
            end
        end
    end

    always_comb begin
        single_status = ST_QUEUE_EMPTY;
        single_slot   = '0;
        slot_ok       = 1'b0;
        push_ok       = 1'b0;
        case (r_act)
            ACT_REGISTER: begin
                if (r_sid == ID_NONE || r_sid == BROADCAST_ID) begin
                    single_status = ST_INVALID_ID;
                end else if (r_slot_cnt == SLOT_CNT_W'(SLOT_COUNT)) begin
                    single_status = ST_TABLE_FULL;
                end else begin
                    single_status = ST_REGISTERED;
                    single_slot   = r_slot_cnt[SLOT_IDX_W-1:0];
                    slot_ok       = 1'b1;
                end
            end
            ACT_PUSH: begin
                if (tail_next == r_head) begin
                    single_status = ST_QUEUE_FULL;
                end else if (r_len > LEN_W'(PAYLOAD_BYTES)) begin
                    single_status = ST_TOO_LONG;
                end else begin
                    single_status = ST_PUSHED;
                    push_ok       = 1'b1;
                end
            end
            default: begin
                single_status = ST_QUEUE_EMPTY;
            end
        endcase
    end

    assign slot_wr = i_cmd.emit_single && slot_ok;
    assign push_wr = i_cmd.emit_single && push_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_cnt <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot[i] <= ID_NONE;
            end
        end else if (slot_wr) begin
            r_slot[single_slot] <= r_sid;
            r_slot_cnt          <= r_slot_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_wr) begin
            r_mem[r_tail] <= '{rcp: r_rcp, msg_type: r_type, payload: payload_masked,
                               len: r_len};
        end
        r_rd <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            if (push_wr) begin
                r_tail <= tail_next;
            end
            if (i_cmd.emit_walk && walk_last) begin
                r_head <= ptr_next(r_head);
            end
        end
    end

    // one match bit per used slot
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            mask_n[i] = (SLOT_CNT_W'(i) < r_slot_cnt)
                     && (r_rd.rcp == BROADCAST_ID || r_slot[i] == r_rd.rcp);
        end
    end

    always_comb begin
        walk_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                walk_idx = SLOT_IDX_W'(i);
            end
        end
    end

    assign mask_clr  = r_mask & ~(SLOT_COUNT'(1) << walk_idx);
    assign walk_last = (mask_clr == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.build_mask) begin
            r_mask <= mask_n;
        end else if (i_cmd.emit_walk) begin
            r_mask <= mask_clr;
        end
    end

    // output register
    assign out_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit_single || i_cmd.emit_walk) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_single) begin
            r_ostatus  <= single_status;
            r_oslot    <= single_slot;
            r_otarget  <= '0;
            r_otype    <= '0;
            r_opayload <= '0;
            r_olen     <= '0;
            r_olast    <= 1'b1;
        end else if (i_cmd.emit_walk) begin
            if (r_mask != '0) begin
                r_ostatus  <= ST_DELIVERY;
                r_oslot    <= walk_idx;
                r_otarget  <= r_slot[walk_idx];
                r_otype    <= r_rd.msg_type;
                r_opayload <= r_rd.payload;
                r_olen     <= r_rd.len;
                r_olast    <= walk_last;
            end else begin
                r_ostatus  <= ST_NO_RECEIVER;
                r_oslot    <= '0;
                r_otarget  <= '0;
                r_otype    <= '0;
                r_opayload <= '0;
                r_olen     <= '0;
                r_olast    <= 1'b1;
            end
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_status = r_ostatus;
    assign o_out_last   = r_olast;
    assign o_out_data   = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                           r_olen, r_opayload, r_otype, r_otarget, r_oslot};

    assign o_sts.q_empty   = (r_head == r_tail);
    assign o_sts.out_free  = out_free;
    assign o_sts.walk_last = walk_last;

endmodule

// File: hdl/mqd_checker.sv
// port-level checks for the message queue dispatcher, bound to the top level
// depends on mqd_pkg and message_queue_dispatcher_top_defines.svh
`include "message_queue_dispatcher_top_defines.svh"

module mqd_checker
    import mqd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [ACTION_W-1:0]   s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [STATUS_W-1:0]   m_axis_tuser,
    input logic                  m_axis_tlast
);

    // a stalled result beat holds
    `MQD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result beat changed under stall")

    // a real command keeps the input closed the next cycle
    `MQD_ASSERT_NEXT(a_busy_after_cmd, s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_REGISTER || s_axis_tuser == ACT_PUSH || s_axis_tuser == ACT_DISPATCH), !s_axis_tready, "input ready right after a command")

    // only deliveries can be followed by more beats
    `MQD_ASSERT_IMPLY(a_status_last, m_axis_tvalid && m_axis_tuser != ST_DELIVERY, m_axis_tlast, "non-delivery status without tlast")

    // no new command while a delivery run is unfinished
    `MQD_ASSERT_IMPLY(a_no_cmd_mid_run, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input ready during a delivery run")

endmodule

bind message_queue_dispatcher_top mqd_checker u_mqd_checker (.*);

// File: tb/message_queue_dispatcher_top_test.sv
// self-checking testbench for message_queue_dispatcher_top: stream driver, stream monitor
// and a cycle-free mailbox predictor; depends on mqd_pkg and message_queue_dispatcher_top
module message_queue_dispatcher_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mqd_pkg::*;

    // the block takes and drops this action without a result
    localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;
    // cycles with no beat on either side before the run is called hung
    localparam int IDLE_LIMIT = 1000;
    // extra cycles after the last expected beat, a full dispatch and then some
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_ITEMS = 280;

    typedef struct {
        logic [ACTION_W-1:0]  action;
        logic [ID_W-1:0]      id;
        logic [ID_W-1:0]      rcp;
        logic [TYPE_W-1:0]    mtype;
        logic [PAYLOAD_W-1:0] payload;
        logic [LEN_W-1:0]     len;
    } t_cmd;

    typedef struct {
        t_status               status;
        logic [SLOT_IDX_W-1:0] slot;
        logic [ID_W-1:0]       svc;
        logic [TYPE_W-1:0]     mtype;
        logic [PAYLOAD_W-1:0]  payload;
        logic [LEN_W-1:0]      len;
        logic                  last;
    } t_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // service_id, recipient, msg_type, payload, payload_length, zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // action
    logic [ACTION_W-1:0]   s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // slot_index, target_service, out_type, out_payload, out_length, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // status
    logic [STATUS_W-1:0]   m_axis_tuser;
    logic                  m_axis_tlast;

    // commands waiting to go out, front one is on the bus while tvalid is high
    t_cmd  cmd_pending[$];
    // result beats owed by the block, oldest first
    t_beat due_beats[$];

    // mirror of the mailbox state
    logic [ID_W-1:0]      ring_rcp[QUEUE_DEPTH];
    logic [TYPE_W-1:0]    ring_type[QUEUE_DEPTH];
    logic [PAYLOAD_W-1:0] ring_payload[QUEUE_DEPTH];
    logic [LEN_W-1:0]     ring_len[QUEUE_DEPTH];
    int                   ring_rd = 0;
    int                   ring_wr = 0;
    logic [ID_W-1:0]      svc_table[SLOT_COUNT];

    // generation-time bookkeeping
    int              gen_fill = 0;
    int              gen_real = 0;
    logic [ID_W-1:0] id_pool[$];

    int fail_count = 0;
    int idle_cycles = 0;

    // sender burst shaping
    int tx_burst_left = 4;
    int tx_gap_left = 0;

    // receiver stall shaping
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_stall_left = 0;
    int rx_tick = 0;

    message_queue_dispatcher_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int ring_next(int p);
        return (p == QUEUE_DEPTH - 1) ? 0 : p + 1;
    endfunction

    function automatic void owe_beat(t_status st, int slot, logic [ID_W-1:0] svc,
                                     logic [TYPE_W-1:0] mtype,
                                     logic [PAYLOAD_W-1:0] payload, logic [LEN_W-1:0] len);
        t_beat b;
        b.status  = st;
        b.slot    = SLOT_IDX_W'(slot);
        b.svc     = svc;
        b.mtype   = mtype;
        b.payload = payload;
        b.len     = len;
        b.last    = 1'b0;
        due_beats.push_back(b);
    endfunction

    // reaction of the mailbox to one accepted command: updates the mirror
    // and appends the beats the block owes for it
    function automatic void mailbox_step(t_cmd c);
        int                   first_free;
        int                   owed_before;
        logic [PAYLOAD_W-1:0] kept;
        owed_before = due_beats.size();
        first_free  = -1;
        if (c.action == ACT_REGISTER) begin
            if (c.id == ID_NONE || c.id == BROADCAST_ID) begin
                owe_beat(ST_INVALID_ID, 0, '0, '0, '0, '0);
            end else begin
                for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
                    if (svc_table[i] == ID_NONE) first_free = i;
                end
                if (first_free < 0) begin
                    owe_beat(ST_TABLE_FULL, 0, '0, '0, '0, '0);
                end else begin
                    svc_table[first_free] = c.id;
                    owe_beat(ST_REGISTERED, first_free, '0, '0, '0, '0);
                end
            end
        end else if (c.action == ACT_PUSH) begin
            // a full ring wins over an oversized payload
            if (ring_next(ring_wr) == ring_rd) begin
                owe_beat(ST_QUEUE_FULL, 0, '0, '0, '0, '0);
            end else if (c.len > PAYLOAD_BYTES) begin
                owe_beat(ST_TOO_LONG, 0, '0, '0, '0, '0);
            end else begin
                // bytes past the length are stored as zero
                kept = c.payload;
                if (c.len < 8) kept &= (64'd1 << (8 * c.len)) - 64'd1;
                ring_rcp[ring_wr]     = c.rcp;
                ring_type[ring_wr]    = c.mtype;
                ring_payload[ring_wr] = kept;
                ring_len[ring_wr]     = c.len;
                ring_wr               = ring_next(ring_wr);
                owe_beat(ST_PUSHED, 0, '0, '0, '0, '0);
            end
        end else if (c.action == ACT_DISPATCH) begin
            if (ring_rd == ring_wr) begin
                owe_beat(ST_QUEUE_EMPTY, 0, '0, '0, '0, '0);
            end else begin
                // walk stops at the first empty slot
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (svc_table[i] == ID_NONE) break;
                    if (ring_rcp[ring_rd] == BROADCAST_ID || svc_table[i] == ring_rcp[ring_rd])
                        owe_beat(ST_DELIVERY, i, svc_table[i], ring_type[ring_rd],
                                 ring_payload[ring_rd], ring_len[ring_rd]);
                end
                if (due_beats.size() == owed_before)
                    owe_beat(ST_NO_RECEIVER, 0, '0, '0, '0, '0);
                ring_rd = ring_next(ring_rd);
            end
        end
        if (due_beats.size() > owed_before) due_beats[due_beats.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(string fname, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            fail_count++;
        end
    endfunction

    // stimulus builders; they also keep a rough count of ring occupancy
    function automatic void queue_cmd(logic [ACTION_W-1:0] action, logic [ID_W-1:0] id,
                                      logic [ID_W-1:0] rcp, logic [TYPE_W-1:0] mtype,
                                      logic [PAYLOAD_W-1:0] payload, logic [LEN_W-1:0] len);
        t_cmd c;
        c.action  = action;
        c.id      = id;
        c.rcp     = rcp;
        c.mtype   = mtype;
        c.payload = payload;
        c.len     = len;
        cmd_pending.push_back(c);
        if (action == ACT_PUSH && len <= PAYLOAD_BYTES && gen_fill < QUEUE_DEPTH - 1)
            gen_fill++;
        if (action == ACT_DISPATCH && gen_fill > 0) gen_fill--;
        if (action != ACT_IGNORED) gen_real++;
    endfunction

    function automatic logic [PAYLOAD_W-1:0] any_payload();
        return {$urandom, $urandom};
    endfunction

    // mostly valid lengths, now and then an oversized one
    function automatic logic [LEN_W-1:0] any_len();
        if ($urandom_range(0, 9) == 0) return LEN_W'($urandom_range(PAYLOAD_BYTES + 1, 15));
        return LEN_W'($urandom_range(0, PAYLOAD_BYTES));
    endfunction

    // recipients lean toward ids that were registered so deliveries happen
    function automatic logic [ID_W-1:0] any_recipient();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5 && id_pool.size() > 0) return id_pool[$urandom_range(0, id_pool.size() - 1)];
        if (pick < 7) return BROADCAST_ID;
        return ID_W'($urandom_range(0, 255));
    endfunction

    function automatic void queue_register();
        logic [ID_W-1:0] id;
        int              pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) id = ($urandom_range(0, 1) == 1) ? BROADCAST_ID : ID_NONE;
        else if (pick < 4 && id_pool.size() > 0) id = id_pool[$urandom_range(0, id_pool.size() - 1)];
        else id = ID_W'($urandom_range(1, 254));
        if (id != ID_NONE && id != BROADCAST_ID) id_pool.push_back(id);
        queue_cmd(ACT_REGISTER, id, ID_W'($urandom), TYPE_W'($urandom), any_payload(),
                  LEN_W'($urandom));
    endfunction

    function automatic void queue_push();
        queue_cmd(ACT_PUSH, ID_W'($urandom), any_recipient(), TYPE_W'($urandom_range(0, 255)),
                  any_payload(), any_len());
    endfunction

    function automatic void queue_dispatch();
        queue_cmd(ACT_DISPATCH, ID_W'($urandom), ID_W'($urandom), TYPE_W'($urandom),
                  any_payload(), LEN_W'($urandom));
    endfunction

    // sender: bursts of beats with random gaps, command held until taken
    always @(posedge i_clk) begin : drive_cmds
        logic holding;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end else begin
            holding = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                mailbox_step(cmd_pending.pop_front());
                holding = 1'b0;
                if (tx_burst_left > 0) tx_burst_left--;
                if (tx_burst_left == 0) begin
                    tx_burst_left = $urandom_range(1, 12);
                    tx_gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            if (!holding) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (cmd_pending.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, cmd_pending[0].len,
                                      cmd_pending[0].payload, cmd_pending[0].mtype,
                                      cmd_pending[0].rcp, cmd_pending[0].id};
                    s_axis_tuser  <= cmd_pending[0].action;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: switches between no stalls, short random stalls, long stalls
    // and an every-other-cycle pattern
    always @(posedge i_clk) begin : drive_ready
        logic rdy;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            rx_tick++;
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(40, 200);
            end else begin
                rx_mode_left--;
            end
            rdy = 1'b1;
            if (rx_stall_left > 0) begin
                rx_stall_left--;
                rdy = 1'b0;
            end else if (rx_mode == 1 && $urandom_range(0, 3) == 0) begin
                rx_stall_left = $urandom_range(0, 2);
                rdy = 1'b0;
            end else if (rx_mode == 2 && $urandom_range(0, 9) == 0) begin
                rx_stall_left = $urandom_range(3, 12);
                rdy = 1'b0;
            end else if (rx_mode == 3) begin
                rdy = rx_tick[0];
            end
            m_axis_tready <= rdy;
        end
    end

    // monitor: every accepted result beat against the oldest owed beat
    always @(posedge i_clk) begin : watch_results
        t_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_beats.size() == 0) begin
                $display("%0t: result beat with none expected, status %0h, tdata %0h",
                         $time, m_axis_tuser, m_axis_tdata);
                fail_count++;
            end else begin
                want = due_beats.pop_front();
                check_field("status", 64'(want.status), 64'(m_axis_tuser));
                check_field("slot_index", 64'(want.slot), 64'(m_axis_tdata[SLOT_IDX_W-1:0]));
                check_field("target_service", 64'(want.svc),
                            64'(m_axis_tdata[SLOT_IDX_W +: ID_W]));
                check_field("out_type", 64'(want.mtype),
                            64'(m_axis_tdata[SLOT_IDX_W + ID_W +: TYPE_W]));
                check_field("out_payload", want.payload,
                            m_axis_tdata[SLOT_IDX_W + ID_W + TYPE_W +: PAYLOAD_W]);
                check_field("out_length", 64'(want.len),
                            64'(m_axis_tdata[SLOT_IDX_W + ID_W + TYPE_W + PAYLOAD_W +: LEN_W]));
                check_field("pad", 64'd0, 64'(m_axis_tdata[OUT_DATA_W-1:OUT_FIELDS_W]));
                check_field("last", 64'(want.last), 64'(m_axis_tlast));
            end
        end
    end

    // watchdog: any beat on either side counts as progress
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : run
        int n;
        for (int i = 0; i < SLOT_COUNT; i++) svc_table[i] = ID_NONE;

        // directed: empty ring, bad ids, dropped action, zero length with
        // an empty table, duplicates, broadcast, oversized payloads
        queue_dispatch();
        queue_cmd(ACT_REGISTER, ID_NONE, '0, '0, '0, '0);
        queue_cmd(ACT_REGISTER, BROADCAST_ID, '1, '1, '1, '1);
        queue_cmd(ACT_IGNORED, '1, '1, '1, '1, '1);
        queue_cmd(ACT_PUSH, '0, 8'd5, 8'h00, '1, 4'd0);
        queue_dispatch();
        queue_cmd(ACT_REGISTER, 8'd5, '0, '0, '0, '0);
        queue_cmd(ACT_REGISTER, 8'd5, '0, '0, '0, '0);
        queue_cmd(ACT_REGISTER, 8'd200, '0, '0, '0, '0);
        id_pool.push_back(8'd5);
        id_pool.push_back(8'd200);
        queue_cmd(ACT_PUSH, '0, 8'd5, 8'hff, '1, 4'd8);
        queue_cmd(ACT_PUSH, '0, BROADCAST_ID, 8'h5a, any_payload(), 4'd3);
        queue_cmd(ACT_PUSH, '0, 8'd9, 8'h11, any_payload(), 4'd9);
        queue_cmd(ACT_PUSH, '1, 8'd9, 8'h22, '1, 4'd15);
        queue_cmd(ACT_PUSH, '0, 8'd1, 8'h80, any_payload(), 4'd1);
        repeat (4) queue_dispatch();
        queue_cmd(ACT_PUSH, '0, 8'd200, 8'h3c, any_payload(), 4'd7);
        queue_dispatch();

        // random: fill the ring past full, drain it past empty, or mix
        gen_real = 0;
        while (gen_real < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    while (gen_fill < QUEUE_DEPTH - 1) queue_push();
                    repeat ($urandom_range(1, 2)) queue_push();
                end
                2, 3: begin
                    n = gen_fill + $urandom_range(0, 1);
                    repeat (n) queue_dispatch();
                end
                default: begin
                    repeat ($urandom_range(4, 12)) begin
                        n = $urandom_range(0, 99);
                        if (n < 8) queue_register();
                        else if (n < 52) queue_push();
                        else if (n < 93) queue_dispatch();
                        else queue_cmd(ACT_IGNORED, ID_W'($urandom), ID_W'($urandom),
                                       TYPE_W'($urandom), any_payload(), LEN_W'($urandom));
                    end
                end
            endcase
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // everything sent and every owed beat seen, then a quiet tail
        while (cmd_pending.size() > 0 || due_beats.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
